// ===== rtl/lbb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lbb_pkg;

  // fixed field widths of the item and result words
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned LABEL_W = 10;
  localparam int unsigned POS_W   = 12;
  localparam int unsigned PAD_W   = 13;

  // widest padded extent that fits the result field
  localparam logic [PAD_W-1:0] PAD_MAX = '1;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  // controller states
  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_LOOKUP,
    ST_EXEC
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic lookup;
    logic exec;
    logic sweep;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_last;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/label_bounding_box_table.sv =====
// channel   ports                                   handshake
// -------   -------------------------------------   ---------------------------
// command   kind_i voxel_label_i pos_x/y/z_i        start_i high, busy_o low
// result    seen_o min/max_x/y/z_o top_label_o      valid_o high for one cycle
//           pad_width_x/y/z_o
//
// an update, read or unused word holds busy_o high through a lookup state (table
// read) and an exec state (table write or result capture); a read's result
// strobes in the cycle after that, while the next word can already be taken.
// a clear word sweeps the table, one entry a cycle, over min(LABEL_COUNT, 1024)
// entries with busy_o high. the same sweep runs right after reset.
// the receiver cannot stall: a result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module label_bounding_box_table #(
  parameter int unsigned LABEL_COUNT = 1024,
  parameter int unsigned COORD_BITS  = 12
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [lbb_pkg::KIND_W-1:0]    kind_i,
  input  wire logic [lbb_pkg::LABEL_W-1:0]   voxel_label_i,
  input  wire logic [lbb_pkg::POS_W-1:0]     pos_x_i,
  input  wire logic [lbb_pkg::POS_W-1:0]     pos_y_i,
  input  wire logic [lbb_pkg::POS_W-1:0]     pos_z_i,
  output logic                               valid_o,
  output logic                               seen_o,
  output logic [lbb_pkg::POS_W-1:0]          min_x_o,
  output logic [lbb_pkg::POS_W-1:0]          min_y_o,
  output logic [lbb_pkg::POS_W-1:0]          min_z_o,
  output logic [lbb_pkg::POS_W-1:0]          max_x_o,
  output logic [lbb_pkg::POS_W-1:0]          max_y_o,
  output logic [lbb_pkg::POS_W-1:0]          max_z_o,
  output logic [lbb_pkg::LABEL_W-1:0]        top_label_o,
  output logic [lbb_pkg::PAD_W-1:0]          pad_width_x_o,
  output logic [lbb_pkg::PAD_W-1:0]          pad_width_y_o,
  output logic [lbb_pkg::PAD_W-1:0]          pad_width_z_o
);

  lbb_pkg::cmd_t    cmd;
  lbb_pkg::status_t status;

  // sequencer
  lbb_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .kind_i   (kind_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // box table and global maxima
  lbb_dpath #(
    .LABEL_COUNT (LABEL_COUNT),
    .COORD_BITS  (COORD_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .kind_i        (kind_i),
    .voxel_label_i (voxel_label_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pos_z_i       (pos_z_i),
    .valid_o       (valid_o),
    .seen_o        (seen_o),
    .min_x_o       (min_x_o),
    .min_y_o       (min_y_o),
    .min_z_o       (min_z_o),
    .max_x_o       (max_x_o),
    .max_y_o       (max_y_o),
    .max_z_o       (max_z_o),
    .top_label_o   (top_label_o),
    .pad_width_x_o (pad_width_x_o),
    .pad_width_y_o (pad_width_y_o),
    .pad_width_z_o (pad_width_z_o)
  );

endmodule

`default_nettype wire

// ===== rtl/lbb_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lbb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic                     we_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lbb_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lbb_ctrl (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [lbb_pkg::KIND_W-1:0]   kind_i,
  input  wire lbb_pkg::status_t             status_i,
  output lbb_pkg::cmd_t                     cmd_o,
  output logic                              busy_o
);

  lbb_pkg::state_e state_q, state_d;

  // state register, reset starts with a table sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lbb_pkg::ST_SWEEP;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lbb_pkg::ST_SWEEP: begin
        if (status_i.sweep_last) begin
          state_d = lbb_pkg::ST_IDLE;
        end
      end
      lbb_pkg::ST_IDLE: begin
        if (start_i) begin
          if (kind_i == lbb_pkg::KIND_CLEAR) begin
            state_d = lbb_pkg::ST_SWEEP;
          end else begin
            state_d = lbb_pkg::ST_LOOKUP;
          end
        end
      end
      lbb_pkg::ST_LOOKUP: state_d = lbb_pkg::ST_EXEC;
      lbb_pkg::ST_EXEC:   state_d = lbb_pkg::ST_IDLE;
      default:            state_d = lbb_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      lbb_pkg::ST_SWEEP:  cmd_o.sweep = 1'b1;
      lbb_pkg::ST_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      lbb_pkg::ST_LOOKUP: cmd_o.lookup = 1'b1;
      lbb_pkg::ST_EXEC:   cmd_o.exec = 1'b1;
      default:            busy_o = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/lbb_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lbb_dpath #(
  parameter int unsigned LABEL_COUNT = 1024,
  parameter int unsigned COORD_BITS  = 12
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire lbb_pkg::cmd_t                 cmd_i,
  output lbb_pkg::status_t                   status_o,
  input  wire logic [lbb_pkg::KIND_W-1:0]    kind_i,
  input  wire logic [lbb_pkg::LABEL_W-1:0]   voxel_label_i,
  input  wire logic [lbb_pkg::POS_W-1:0]     pos_x_i,
  input  wire logic [lbb_pkg::POS_W-1:0]     pos_y_i,
  input  wire logic [lbb_pkg::POS_W-1:0]     pos_z_i,
  output logic                               valid_o,
  output logic                               seen_o,
  output logic [lbb_pkg::POS_W-1:0]          min_x_o,
  output logic [lbb_pkg::POS_W-1:0]          min_y_o,
  output logic [lbb_pkg::POS_W-1:0]          min_z_o,
  output logic [lbb_pkg::POS_W-1:0]          max_x_o,
  output logic [lbb_pkg::POS_W-1:0]          max_y_o,
  output logic [lbb_pkg::POS_W-1:0]          max_z_o,
  output logic [lbb_pkg::LABEL_W-1:0]        top_label_o,
  output logic [lbb_pkg::PAD_W-1:0]          pad_width_x_o,
  output logic [lbb_pkg::PAD_W-1:0]          pad_width_y_o,
  output logic [lbb_pkg::PAD_W-1:0]          pad_width_z_o
);

  // labels above the label field never reach the table
  localparam int unsigned LABEL_SPAN = 1 << lbb_pkg::LABEL_W;
  localparam int unsigned DEPTH = (LABEL_COUNT < LABEL_SPAN) ? LABEL_COUNT : LABEL_SPAN;
  localparam int unsigned AW    = $clog2(DEPTH);
  // coordinates are held in the bits that the position fields carry
  localparam int unsigned CW    = (COORD_BITS < lbb_pkg::POS_W) ? COORD_BITS : lbb_pkg::POS_W;
  localparam int unsigned EW    = CW + 1;
  localparam int unsigned RW    = 6 * CW + 1;

  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [16:0]   LBL_LIMIT = 17'(LABEL_COUNT);

  // latched item
  logic [lbb_pkg::KIND_W-1:0] kind_q;
  logic [AW-1:0]              addr_q;
  logic                       ok_q;
  logic [CW-1:0]              pos_q [3];
  logic                       lbl_ok;

  // global maxima
  logic [lbb_pkg::LABEL_W-1:0] lab_q;
  logic [lbb_pkg::LABEL_W-1:0] top_q;
  logic [EW-1:0]               ext_q [3];
  logic [EW-1:0]               ext_d [3];

  // sweep counter
  logic [AW-1:0] cnt_q;

  // table access
  logic [AW-1:0] ram_addr;
  logic          ram_we;
  logic [RW-1:0] ram_wdata;
  logic [RW-1:0] ram_rdata;
  logic          upd_go;
  logic          hit;

  logic [CW-1:0] lo_r  [3];
  logic [CW-1:0] hi_r  [3];
  logic [CW-1:0] lo_n  [3];
  logic [CW-1:0] hi_n  [3];
  logic [EW-1:0] span  [3];
  logic [lbb_pkg::PAD_W:0] pad_sum [3];
  logic [lbb_pkg::PAD_W-1:0] pad   [3];

  assign lbl_ok = (voxel_label_i != '0) && (17'(voxel_label_i) < LBL_LIMIT);

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q   <= kind_i;
      addr_q   <= voxel_label_i[AW-1:0];
      lab_q    <= voxel_label_i;
      ok_q     <= lbl_ok;
      pos_q[0] <= pos_x_i[CW-1:0];
      pos_q[1] <= pos_y_i[CW-1:0];
      pos_q[2] <= pos_z_i[CW-1:0];
    end
  end

  // sweep address, restarts on every clear word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load && kind_i == lbb_pkg::KIND_CLEAR) begin
      cnt_q <= '0;
    end else if (cmd_i.sweep) begin
      cnt_q <= cnt_q + AW'(1);
    end
  end

  assign status_o.sweep_last = (cnt_q == LAST_ADDR);

  // unpack the entry read for this word
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      lo_r[a] = ram_rdata[a*CW +: CW];
      hi_r[a] = ram_rdata[(3+a)*CW +: CW];
    end
  end

  assign hit    = ok_q && ram_rdata[6*CW];
  assign upd_go = cmd_i.exec && ok_q && (kind_q == lbb_pkg::KIND_UPDATE);

  // grow the box and the global extents
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (!hit) begin
        lo_n[a] = pos_q[a];
        hi_n[a] = pos_q[a];
      end else begin
        lo_n[a] = (pos_q[a] < lo_r[a]) ? pos_q[a] : lo_r[a];
        hi_n[a] = (pos_q[a] > hi_r[a]) ? pos_q[a] : hi_r[a];
      end
      span[a]  = EW'(hi_n[a]) - EW'(lo_n[a]) + EW'(1);
      ext_d[a] = (span[a] > ext_q[a]) ? span[a] : ext_q[a];
    end
  end

  // write back, the sweep writes empty entries
  always_comb begin
    ram_addr  = cnt_q;
    ram_we    = cmd_i.sweep;
    ram_wdata = '0;
    if (!cmd_i.sweep) begin
      ram_addr  = addr_q;
      ram_we    = upd_go;
      ram_wdata = {1'b1, hi_n[2], hi_n[1], hi_n[0], lo_n[2], lo_n[1], lo_n[0]};
    end
  end

  lbb_ram #(
    .WIDTH (RW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .addr_i  (ram_addr),
    .we_i    (ram_we),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.lookup),
    .rdata_o (ram_rdata)
  );

  // largest label and extents, zeroed by reset and clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= '0;
      for (int a = 0; a < 3; a++) begin
        ext_q[a] <= '0;
      end
    end else if (cmd_i.load && kind_i == lbb_pkg::KIND_CLEAR) begin
      top_q <= '0;
      for (int a = 0; a < 3; a++) begin
        ext_q[a] <= '0;
      end
    end else if (upd_go) begin
      if (lab_q > top_q) begin
        top_q <= lab_q;
      end
      for (int a = 0; a < 3; a++) begin
        ext_q[a] <= ext_d[a];
      end
    end
  end

  // padded extents, saturated to the field
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      pad_sum[a] = (lbb_pkg::PAD_W + 1)'(ext_q[a]) + (lbb_pkg::PAD_W + 1)'(2);
      if (pad_sum[a] > (lbb_pkg::PAD_W + 1)'(lbb_pkg::PAD_MAX)) begin
        pad[a] = lbb_pkg::PAD_MAX;
      end else begin
        pad[a] = pad_sum[a][lbb_pkg::PAD_W-1:0];
      end
    end
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= cmd_i.exec && (kind_q == lbb_pkg::KIND_READ);
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      seen_o        <= hit;
      min_x_o       <= hit ? lbb_pkg::POS_W'(lo_r[0]) : '0;
      min_y_o       <= hit ? lbb_pkg::POS_W'(lo_r[1]) : '0;
      min_z_o       <= hit ? lbb_pkg::POS_W'(lo_r[2]) : '0;
      max_x_o       <= hit ? lbb_pkg::POS_W'(hi_r[0]) : '0;
      max_y_o       <= hit ? lbb_pkg::POS_W'(hi_r[1]) : '0;
      max_z_o       <= hit ? lbb_pkg::POS_W'(hi_r[2]) : '0;
      top_label_o   <= top_q;
      pad_width_x_o <= pad[0];
      pad_width_y_o <= pad[1];
      pad_width_z_o <= pad[2];
    end
  end

endmodule

`default_nettype wire
